>>> design/cbrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbrm_pkg
// Shared constants and controller/datapath interface types for the channel
// busy ratio monitor.
// ----------------------------------------------------------------------------
package cbrm_pkg;

  // Default build parameters
  localparam int CBRM_COUNT_BITS    = 16;
  localparam int CBRM_FRACTION_BITS = 16;

  // Fixed port field widths
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int WINDOW_W    = 16;
  localparam int WEIGHT_W    = 9;
  localparam int THRESH_W    = 17;
  localparam int TIME_W      = 32;
  localparam int LOAD_OUT_W  = 17;
  localparam int LEVEL_W     = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_WEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 2'd3;

  // Configuration reset values
  localparam logic [WINDOW_W-1:0] WINDOW_MS_RST      = 16'd200;
  localparam logic [WEIGHT_W-1:0] FILTER_WEIGHT_RST  = 9'd128;
  localparam logic [THRESH_W-1:0] HIGH_THRESHOLD_RST = 17'd26214;
  localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RST  = 17'd6554;

  // Full weight in Q8
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  // Request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_PROBE = 1'b1;

  // Congestion levels
  localparam logic [LEVEL_W-1:0] LEVEL_RELAXED = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;        // capture input transaction
    logic clear_start;  // start request: clear window state
    logic count;        // probe inside window: bump counters
    logic div_init;     // load divider with busy/probe counts
    logic div_step;     // one quotient bit
    logic mul_prev;     // weight * previous load
    logic mul_ratio;    // (1 - weight) * ratio
    logic sum;          // round, update load and restart window
    logic emit;         // write result into output register
  } cbrm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_start;     // latched transaction is a start request
    logic in_window;    // latched probe falls inside the window
    logic out_free;     // output register can take a result
  } cbrm_sts_t;

endpackage : cbrm_pkg
`default_nettype wire

>>> design/cbrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbrm_ctrl
// Sequencer for the monitor: evaluates each transaction, steps the serial
// divider and the shared multiplier, and hands the result to the output.
// ----------------------------------------------------------------------------
module cbrm_ctrl
  import cbrm_pkg::*;
#(
  parameter int FRACTION_BITS = CBRM_FRACTION_BITS
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  cbrm_sts_t  sts,
  output cbrm_cmd_t  cmd
);

  localparam int STEP_W = $clog2(FRACTION_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRACTION_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.is_start) begin
          cmd.clear_start = 1'b1;
          state_nxt       = S_IDLE;
        end else if (sts.in_window) begin
          cmd.count = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd.mul_prev = 1'b1;
        state_nxt    = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_ratio = 1'b1;
        state_nxt     = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule : cbrm_ctrl
`default_nettype wire

>>> design/cbrm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbrm_dp
// Datapath: configuration registers, window state, saturating counters,
// restoring divider, shared blend multiplier, classifier and output register.
// ----------------------------------------------------------------------------
module cbrm_dp
  import cbrm_pkg::*;
#(
  parameter int COUNT_BITS    = CBRM_COUNT_BITS,
  parameter int FRACTION_BITS = CBRM_FRACTION_BITS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // configuration
  input  wire                    cfg_valid,
  input  wire [CFG_INDEX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  // input payload
  input  wire                    in_req_type,
  input  wire [TIME_W-1:0]       in_now_ms,
  input  wire                    in_phy_busy,
  // result channel
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [LOAD_OUT_W-1:0]  out_channel_load,
  output logic [LEVEL_W-1:0]     out_load_level,
  // control
  input  cbrm_cmd_t              cmd,
  output cbrm_sts_t              sts
);

  localparam int LOAD_W = FRACTION_BITS + 1;
  localparam int PROD_W = WEIGHT_W + LOAD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CMP_W  = (LOAD_W > THRESH_W) ? LOAD_W : THRESH_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(128);

  // Configuration registers
  logic [WINDOW_W-1:0] window_ms_r;
  logic [WEIGHT_W-1:0] filter_weight_r;
  logic [THRESH_W-1:0] high_threshold_r;
  logic [THRESH_W-1:0] low_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r      <= WINDOW_MS_RST;
      filter_weight_r  <= FILTER_WEIGHT_RST;
      high_threshold_r <= HIGH_THRESHOLD_RST;
      low_threshold_r  <= LOW_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_MS:      window_ms_r      <= cfg_data[WINDOW_W-1:0];
        REG_FILTER_WEIGHT:  filter_weight_r  <= cfg_data[WEIGHT_W-1:0];
        REG_HIGH_THRESHOLD: high_threshold_r <= cfg_data[THRESH_W-1:0];
        REG_LOW_THRESHOLD:  low_threshold_r  <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched transaction
  logic              req_r;
  logic [TIME_W-1:0] now_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_req_type;
      now_r  <= in_now_ms;
      busy_r <= in_phy_busy;
    end
  end

  // Window state
  logic [TIME_W-1:0]     window_start_r;
  logic [COUNT_BITS-1:0] probe_count_r;
  logic [COUNT_BITS-1:0] busy_count_r;
  logic [LOAD_W-1:0]     prev_load_r;
  logic [LOAD_W-1:0]     load_r;
  logic [LOAD_W-1:0]     load_nxt;
  logic [TIME_W-1:0]     elapsed;

  assign elapsed = now_r - window_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_start_r <= '0;
      probe_count_r  <= '0;
      busy_count_r   <= '0;
      prev_load_r    <= '0;
    end else if (cmd.clear_start) begin
      window_start_r <= now_r;
      probe_count_r  <= '0;
      busy_count_r   <= '0;
      prev_load_r    <= '0;
    end else if (cmd.count) begin
      // saturating; busy only counts along with a probe
      if (probe_count_r != COUNT_MAX) begin
        probe_count_r <= probe_count_r + 1'b1;
        if (busy_r && (busy_count_r != COUNT_MAX)) begin
          busy_count_r <= busy_count_r + 1'b1;
        end
      end
    end else if (cmd.sum) begin
      window_start_r <= now_r;
      probe_count_r  <= '0;
      busy_count_r   <= '0;
      prev_load_r    <= load_nxt;
    end
  end

  // Restoring divider: quotient of (busy << F) / probe, one bit a cycle.
  // busy <= probe, so the remainder always stays below the divisor.
  logic [COUNT_BITS-1:0] rem_r;
  logic [LOAD_W-1:0]     quo_r;
  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   divisor;
  logic                  div_nonzero;
  logic                  init_take;
  logic                  step_take;

  assign divisor     = {1'b0, probe_count_r};
  assign div_nonzero = (probe_count_r != '0);
  assign rem_shift   = {rem_r, 1'b0};
  assign init_take   = div_nonzero && (busy_count_r >= probe_count_r);
  assign step_take   = div_nonzero && (rem_shift >= divisor);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r <= {{FRACTION_BITS{1'b0}}, init_take};
      rem_r <= init_take ? (busy_count_r - probe_count_r) : busy_count_r;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[LOAD_W-2:0], step_take};
      if (step_take) begin
        rem_r <= COUNT_BITS'(rem_shift - divisor);
      end else begin
        rem_r <= rem_shift[COUNT_BITS-1:0];
      end
    end
  end

  // Shared multiplier for the smoothing filter
  logic [WEIGHT_W-1:0] weight_sat;
  logic [WEIGHT_W-1:0] mul_a;
  logic [LOAD_W-1:0]   mul_b;
  logic [PROD_W-1:0]   product;
  logic [PROD_W-1:0]   prod_prev_r;
  logic [PROD_W-1:0]   prod_ratio_r;
  logic [SUM_W-1:0]    blend_sum;

  assign weight_sat = (filter_weight_r > WEIGHT_ONE) ? WEIGHT_ONE : filter_weight_r;
  assign mul_a      = cmd.mul_ratio ? (WEIGHT_ONE - weight_sat) : weight_sat;
  assign mul_b      = cmd.mul_ratio ? quo_r : prev_load_r;
  assign product    = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_prev) begin
      prod_prev_r <= product;
    end
    if (cmd.mul_ratio) begin
      prod_ratio_r <= product;
    end
  end

  // Round to nearest, halves up
  assign blend_sum = SUM_W'(prod_prev_r) + SUM_W'(prod_ratio_r) + ROUND_HALF;
  assign load_nxt  = blend_sum[LOAD_W+7:8];

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      load_r <= load_nxt;
    end
  end

  // Classifier
  logic [CMP_W-1:0]   load_cmp;
  logic [LEVEL_W-1:0] level;

  assign load_cmp = CMP_W'(load_r);

  always_comb begin
    if (load_cmp > CMP_W'(high_threshold_r)) begin
      level = LEVEL_HIGH;
    end else if (load_cmp > CMP_W'(low_threshold_r)) begin
      level = LEVEL_MEDIUM;
    end else begin
      level = LEVEL_RELAXED;
    end
  end

  // Output register
  logic                  out_valid_r;
  logic [LOAD_OUT_W-1:0] out_load_r;
  logic [LEVEL_W-1:0]    out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_load_r  <= load_cmp[LOAD_OUT_W-1:0];
      out_level_r <= level;
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_channel_load = out_load_r;
  assign out_load_level   = out_level_r;

  // Status to controller
  assign sts.is_start  = (req_r == REQ_START);
  assign sts.in_window = (elapsed < TIME_W'(window_ms_r));
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule : cbrm_dp
`default_nettype wire

>>> design/channel_busy_ratio_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// A start or an in-window probe gives no result. A probe that closes the window
// puts its result on out_* after S_EVAL, the one-bit-a-cycle divider (S_DIV),
// S_MUL_A, S_MUL_B, S_SUM and S_EMIT in that order. in_tready is high only in
// S_IDLE, so no new transaction is taken before the last is done, and a window
// close waits longer only while the output register is held.
// Reset (rst_n low, synchronous): registers to defaults, window state to zero.
// ----------------------------------------------------------------------------
// channel_busy_ratio_monitor
// Measures the channel busy ratio per time window, smooths it and classifies
// it into three congestion levels.
// ----------------------------------------------------------------------------
module channel_busy_ratio_monitor
  import cbrm_pkg::*;
#(
  parameter int COUNT_BITS    = CBRM_COUNT_BITS,
  parameter int FRACTION_BITS = CBRM_FRACTION_BITS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // configuration write channel
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [CFG_INDEX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,   // [31:0] now_ms, [32] phy_busy, rest zero
  input  wire                    in_tuser,   // [0] req_type
  // result stream
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [16:0] channel_load, [18:17] load_level
);

  cbrm_cmd_t             cmd;
  cbrm_sts_t             sts;
  logic [LOAD_OUT_W-1:0] channel_load;
  logic [LEVEL_W-1:0]    load_level;

  assign cfg_ready = 1'b1;

  cbrm_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbrm_dp #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_tuser),
    .in_now_ms        (in_tdata[TIME_W-1:0]),
    .in_phy_busy      (in_tdata[TIME_W]),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_channel_load (channel_load),
    .out_load_level   (load_level),
    .cmd              (cmd),
    .sts              (sts)
  );

  // Pack result fields, pad to whole bytes
  assign out_tdata = {{(OUT_TDATA_W - LOAD_OUT_W - LEVEL_W){1'b0}}, load_level, channel_load};

endmodule : channel_busy_ratio_monitor
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the channel busy ratio monitor. Start and probe
// transactions go in through the input stream. A local window tracker keeps
// its own window start, counters and previous load, and queues the load and
// level that each window close should produce. Every result transaction is
// checked against the oldest queued entry. Configuration changes happen only
// while the block is drained.
// ----------------------------------------------------------------------------
module tb;
  import cbrm_pkg::*;

  typedef struct packed {
    logic [LOAD_OUT_W-1:0] load;
    logic [LEVEL_W-1:0]    level;
  } load_report_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] now_ms, [32] phy_busy, rest zero
  logic                   in_tuser;   // [0] req_type
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [16:0] channel_load, [18:17] load_level

  channel_busy_ratio_monitor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Register mirror
  logic [WINDOW_W-1:0] cfg_window;
  logic [WEIGHT_W-1:0] cfg_weight;
  logic [THRESH_W-1:0] cfg_high;
  logic [THRESH_W-1:0] cfg_low;

  // Tracked window state
  logic [TIME_W-1:0]          win_start;
  logic [CBRM_COUNT_BITS-1:0] probes;
  logic [CBRM_COUNT_BITS-1:0] busies;
  logic [LOAD_OUT_W-1:0]      prev_load;

  load_report_t due_reports[$];
  load_report_t seen_report;
  load_report_t want_report;
  int           mismatches = 0;
  int           burst_left = 0;
  bit           tx_steady  = 0;
  int unsigned  rx_cycle   = 0;

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Window tracker: updates state for one accepted transaction and queues
  // the report a window close produces.
  function automatic void track_window(input logic req, input logic [TIME_W-1:0] now,
                                       input logic busy);
    logic [TIME_W-1:0]     age;
    logic [LOAD_OUT_W-1:0] ratio;
    longint unsigned       wgt;
    longint unsigned       mix;
    load_report_t          rep;
    if (req == REQ_START) begin
      win_start = now;
      probes    = '0;
      busies    = '0;
      prev_load = '0;
    end else begin
      age = now - win_start;
      if (age < cfg_window) begin
        // counters saturate together; busy only counts with a counted probe
        if (probes != '1) begin
          probes = probes + 1'b1;
          if (busy && busies != '1) busies = busies + 1'b1;
        end
      end else begin
        if (probes == '0) ratio = '0;
        else ratio = LOAD_OUT_W'({busies, {CBRM_FRACTION_BITS{1'b0}}} / probes);
        wgt = (cfg_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_weight;
        mix = (wgt * prev_load + (256 - wgt) * ratio + 128) >> 8;
        rep.load = mix[LOAD_OUT_W-1:0];
        if (rep.load > cfg_high) rep.level = LEVEL_HIGH;
        else if (rep.load > cfg_low) rep.level = LEVEL_MEDIUM;
        else rep.level = LEVEL_RELAXED;
        prev_load = rep.load;
        probes    = '0;
        busies    = '0;
        win_start = now;
        due_reports = {due_reports, rep};
      end
    end
  endfunction

  // Result receiver: the stall pattern is chosen by rx_cycle[8:7]
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= (rx_cycle % 5 == 0);
      default: out_tready <= (rx_cycle[5:0] >= 6'd40);
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      seen_report.load  = out_tdata[16:0];
      seen_report.level = out_tdata[18:17];
      if (due_reports.size() == 0) begin
        $error("unexpected transaction: channel_load %0d load_level %0d",
               seen_report.load, seen_report.level);
        mismatches++;
      end else begin
        want_report = due_reports.pop_front();
        if (seen_report.load !== want_report.load) begin
          $error("channel_load mismatch: expected %0d, got %0d",
                 want_report.load, seen_report.load);
          mismatches++;
        end
        if (seen_report.level !== want_report.level) begin
          $error("load_level mismatch: expected %0d, got %0d",
                 want_report.level, seen_report.level);
          mismatches++;
        end
      end
    end
  end

  // Send one start or probe; called at a falling edge, returns at one
  task automatic send_request(input logic req, input logic [TIME_W-1:0] now,
                              input logic busy);
    int gap;
    if (!tx_steady && burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'b0, busy, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_window(req, now, busy);
    @(negedge clk);
  endtask

  // Hold the sender until every queued report has come back
  task automatic wait_for_results();
    int waited;
    in_tvalid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (due_reports.size() != 0 && waited < 4000) begin
      @(negedge clk);
      waited++;
    end
    if (due_reports.size() != 0) begin
      $error("%0d expected transactions never arrived", due_reports.size());
      mismatches++;
      due_reports.delete();
    end
    // lets the last accepted transaction finish its evaluation
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WINDOW_MS:      cfg_window = val[WINDOW_W-1:0];
      REG_FILTER_WEIGHT:  cfg_weight = val[WEIGHT_W-1:0];
      REG_HIGH_THRESHOLD: cfg_high   = val[THRESH_W-1:0];
      default:            cfg_low    = val[THRESH_W-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [WINDOW_W-1:0] win, input logic [WEIGHT_W-1:0] wgt,
                                input logic [THRESH_W-1:0] hi, input logic [THRESH_W-1:0] lo);
    wait_for_results();
    write_reg(REG_WINDOW_MS, {1'b0, win});
    write_reg(REG_FILTER_WEIGHT, {8'b0, wgt});
    write_reg(REG_HIGH_THRESHOLD, hi);
    write_reg(REG_LOW_THRESHOLD, lo);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Reset values: probe before any start, wrap of the time stamp,
  // window edge, empty windows
  task automatic test_reset_defaults();
    send_request(REQ_PROBE, 32'd10, 1'b1);
    send_request(REQ_PROBE, 32'd200, 1'b1);
    send_request(REQ_PROBE, 32'hFFFF_FFFF, 1'b0);
    send_request(REQ_PROBE, 32'h0000_0010, 1'b1);
    send_request(REQ_PROBE, 32'h0000_00C6, 1'b0);
    send_request(REQ_PROBE, 32'h0000_00C7, 1'b1);
    send_request(REQ_START, 32'h8000_0000, 1'b1);
    send_request(REQ_PROBE, 32'h7FFF_FFFF, 1'b0);
    send_request(REQ_START, 32'hFFFF_FFFF, 1'b0);
    send_request(REQ_PROBE, 32'h0000_0000, 1'b1);
  endtask

  // Register extremes: zero window, full and oversized weight,
  // thresholds out of range and inverted
  task automatic test_register_extremes();
    logic [TIME_W-1:0] t;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: apply_settings(16'd0, 9'd0, 17'd0, 17'd0);
        1: apply_settings(16'd1, WEIGHT_ONE, 17'd65536, 17'd65536);
        2: apply_settings(16'hFFFF, 9'd511, 17'h1FFFF, 17'h1FFFF);
        default: apply_settings(16'd2, 9'd300, 17'd0, 17'd65536);
      endcase
      t = $urandom;
      send_request(REQ_START, t, 1'b1);
      send_request(REQ_PROBE, t, 1'b1);
      send_request(REQ_PROBE, t + cfg_window - 1, 1'b0);
      send_request(REQ_PROBE, t + cfg_window, 1'b1);
    end
  endtask

  // Many busy probes back to back within one long window
  task automatic test_long_window();
    logic [TIME_W-1:0] t;
    apply_settings(16'hFFFF, FILTER_WEIGHT_RST, HIGH_THRESHOLD_RST, LOW_THRESHOLD_RST);
    tx_steady = 1;
    t = $urandom;
    send_request(REQ_START, t, 1'b0);
    for (int n = 0; n < 300; n++) send_request(REQ_PROBE, t, 1'b1);
    for (int n = 0; n < 4; n++) send_request(REQ_PROBE, t + 1, 1'b0);
    send_request(REQ_PROBE, t + 16'hFFFF, 1'b0);
    tx_steady = 0;
  endtask

  // Random windows: mostly time stamps advancing inside the window, some
  // hits right at the window edge, some starts and some random stamps
  task automatic test_random_traffic();
    logic [WINDOW_W-1:0] win;
    logic [WEIGHT_W-1:0] wgt;
    logic [THRESH_W-1:0] hi;
    logic [THRESH_W-1:0] lo;
    logic [TIME_W-1:0]   t;
    int                  bp;
    int                  r;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0: win = 16'd0;
        1: win = 16'd1;
        2: win = 16'hFFFF;
        3, 4: win = WINDOW_W'($urandom_range(2, 20));
        default: win = WINDOW_W'($urandom_range(21, 400));
      endcase
      case ($urandom_range(0, 3))
        0: wgt = 9'd0;
        1: wgt = WEIGHT_ONE;
        2: wgt = WEIGHT_W'($urandom_range(257, 511));
        default: wgt = WEIGHT_W'($urandom_range(0, 256));
      endcase
      hi = THRESH_W'($urandom_range(0, 65536));
      lo = THRESH_W'($urandom_range(0, hi));
      if ($urandom_range(0, 7) == 0) hi = THRESH_W'($urandom_range(65537, 131071));
      if ($urandom_range(0, 7) == 0) lo = THRESH_W'($urandom_range(0, 131071));
      apply_settings(win, wgt, hi, lo);
      tx_steady = (phase % 3 == 2);
      t  = $urandom;
      bp = $urandom_range(0, 100);
      for (int n = 0; n < 160; n++) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) bp = $urandom_range(0, 100);
        if (r < 4) begin
          t = $urandom;
          send_request(REQ_START, t, 1'($urandom_range(0, 1)));
        end else if (r < 10) begin
          t = win_start + cfg_window - 1 + $urandom_range(0, 1);
          send_request(REQ_PROBE, t, $urandom_range(0, 99) < bp);
        end else if (r < 94) begin
          t = t + $urandom_range(0, win / 3 + 1);
          send_request(REQ_PROBE, t, $urandom_range(0, 99) < bp);
        end else begin
          t = $urandom;
          send_request(REQ_PROBE, t, 1'($urandom_range(0, 1)));
        end
      end
    end
    tx_steady = 0;
  endtask

  // Main sequence
  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_START;
    out_tready = 1'b0;
    cfg_window = WINDOW_MS_RST;
    cfg_weight = FILTER_WEIGHT_RST;
    cfg_high   = HIGH_THRESHOLD_RST;
    cfg_low    = LOW_THRESHOLD_RST;
    win_start  = '0;
    probes     = '0;
    busies     = '0;
    prev_load  = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_long_window();
    wait_for_results();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
